// ===== rtl/owm_pkg.sv =====
`default_nettype none
package owm_pkg;

  // Sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_RST_LOW = 3'd1,
    PH_RST_REL = 3'd2,
    PH_WRITE   = 3'd3,
    PH_READ    = 3'd4
  } phase_e;

  // Command codes
  localparam logic [1:0] OP_RESET  = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  // op code with no command behind it
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int unsigned ElapsedW = 10;
  typedef logic [ElapsedW-1:0] elapsed_t;

  // Timing in 1 us ticks
  localparam elapsed_t T_RST_LOW    = 10'd500;
  localparam elapsed_t T_RST_SAMPLE = 10'd70;
  localparam elapsed_t T_RST_WAIT   = 10'd500;
  localparam elapsed_t T_W1_LOW     = 10'd10;
  localparam elapsed_t T_W1_REL     = 10'd75;
  localparam elapsed_t T_W0_LOW     = 10'd80;
  localparam elapsed_t T_RD_LOW     = 10'd8;
  localparam elapsed_t T_RD_SAMPLE  = 10'd4;
  localparam elapsed_t T_RD_WAIT    = 10'd65;

  localparam elapsed_t W_SLOT      = T_W1_LOW + T_W1_REL;
  localparam elapsed_t R_SAMPLE_AT = T_RD_LOW + T_RD_SAMPLE;
  localparam elapsed_t R_SLOT      = R_SAMPLE_AT + T_RD_WAIT;
  localparam elapsed_t RST_REL_LEN = T_RST_SAMPLE + T_RST_WAIT;

endpackage
`default_nettype wire

// ===== rtl/onewire_bus_master.sv =====
// One-wire bus master, standard speed.
// Each input transaction on the s_axis channel is one 1 us tick: tuser carries
// an optional command request (start_req, op) and tdata the byte to write plus
// the sampled line level. Each accepted tick yields exactly one result
// transaction on m_axis with the line drive for that tick and status flags.
// Commands: reset with presence detect (500 us low, sample at +70 us released,
// then 500 us wait), write byte and read byte, LSB first.
// The result of a tick is registered and appears in the cycle after it is accepted.
// Throughput: one tick per cycle while results are taken; the sequencer state and a single output
// register are updated in the accept cycle by short logic.
// A start request while a command runs (its last tick included) is ignored
// and flagged as refused; op code 3 while idle is ignored silently.
// Reset returns the sequencer to idle and clears the shift registers,
// the presence flag and the output register.
// When the receiver stalls, the pending result holds and s_axis_tready drops
// until it is taken; no tick is dropped, so the upstream timebase must stall too.
`default_nettype none
module onewire_bus_master import owm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] write_data, [8] line_level, [15:9] zero
  input  wire logic [15:0] s_axis_tdata,
  // [0] start_req, [2:1] op
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] drive_low, [1] busy_res, [2] done_res, [10:3] read_data,
  // [11] presence, [12] refused, [15:13] zero
  output logic [15:0]      m_axis_tdata
);

  logic       start_req, line_level;
  logic [1:0] op;
  logic [7:0] write_data;

  phase_e     phase_q, phase_d;
  elapsed_t   elapsed_q, elapsed_d;
  logic [2:0] bitpos_q, bitpos_d;
  logic [7:0] send_q, send_d;
  logic [7:0] recv_q, recv_d;
  logic       pres_q, pres_d;

  logic       drive, busy, done, refused;
  logic       wbit;
  logic       accept;
  logic       out_valid_q;
  logic [15:0] out_data_q;

  assign start_req  = s_axis_tuser[0];
  assign op         = s_axis_tuser[2:1];
  assign write_data = s_axis_tdata[7:0];
  assign line_level = s_axis_tdata[8];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Sequencer next state and tick outputs
  always_comb begin
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    bitpos_d  = bitpos_q;
    send_d    = send_q;
    recv_d    = recv_q;
    pres_d    = pres_q;
    drive     = 1'b0;
    done      = 1'b0;
    refused   = 1'b0;
    wbit      = 1'b0;

    // unknown codes fall back to idle
    case (phase_q)
      PH_RST_LOW, PH_RST_REL, PH_WRITE, PH_READ: phase_d = phase_q;
      default: phase_d = PH_IDLE;
    endcase

    // command launch, which already drives on this tick
    if (phase_d == PH_IDLE) begin
      if (start_req && op != OP_UNUSED) begin
        elapsed_d = '0;
        bitpos_d  = '0;
        case (op)
          OP_RESET: phase_d = PH_RST_LOW;
          OP_WRITE: begin
            phase_d = PH_WRITE;
            send_d  = write_data;
          end
          default: begin
            phase_d = PH_READ;
            recv_d  = '0;
          end
        endcase
      end
    end else if (start_req) begin
      refused = 1'b1;
    end

    busy = (phase_d != PH_IDLE);

    case (phase_d)
      PH_RST_LOW: begin
        drive = 1'b1;
        if (elapsed_d >= T_RST_LOW - 10'd1) begin
          phase_d   = PH_RST_REL;
          elapsed_d = '0;
        end else begin
          elapsed_d = elapsed_d + 10'd1;
        end
      end
      PH_RST_REL: begin
        if (elapsed_d == T_RST_SAMPLE) pres_d = !line_level;
        if (elapsed_d >= RST_REL_LEN - 10'd1) begin
          phase_d   = PH_IDLE;
          elapsed_d = '0;
          done      = 1'b1;
        end else begin
          elapsed_d = elapsed_d + 10'd1;
        end
      end
      PH_WRITE: begin
        wbit  = send_d[bitpos_d];
        drive = elapsed_d < (wbit ? T_W1_LOW : T_W0_LOW);
        if (elapsed_d >= W_SLOT - 10'd1) begin
          elapsed_d = '0;
          if (bitpos_d == 3'd7) begin
            bitpos_d = '0;
            phase_d  = PH_IDLE;
            done     = 1'b1;
          end else begin
            bitpos_d = bitpos_d + 3'd1;
          end
        end else begin
          elapsed_d = elapsed_d + 10'd1;
        end
      end
      PH_READ: begin
        drive = elapsed_d < T_RD_LOW;
        if (elapsed_d == R_SAMPLE_AT) recv_d[bitpos_d] = recv_d[bitpos_d] | line_level;
        if (elapsed_d >= R_SLOT - 10'd1) begin
          elapsed_d = '0;
          if (bitpos_d == 3'd7) begin
            bitpos_d = '0;
            phase_d  = PH_IDLE;
            done     = 1'b1;
          end else begin
            bitpos_d = bitpos_d + 3'd1;
          end
        end else begin
          elapsed_d = elapsed_d + 10'd1;
        end
      end
      default: ;
    endcase
  end

  // Sequencer state, advanced once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      elapsed_q <= '0;
      bitpos_q  <= '0;
      send_q    <= '0;
      recv_q    <= '0;
      pres_q    <= 1'b0;
    end else if (accept) begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      bitpos_q  <= bitpos_d;
      send_q    <= send_d;
      recv_q    <= recv_d;
      pres_q    <= pres_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (accept) begin
        out_valid_q <= 1'b1;
        out_data_q  <= {3'b000, refused, pres_d, recv_d, done, busy, drive};
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire
